// ----- hw/rtl/mfp_pkg.sv -----
// shared types, character codes and helpers for the meter frame parser
package mfp_pkg;

   // frame characters
   localparam logic [7:0] CH_STX    = 8'h02;
   localparam logic [7:0] CH_ETX    = 8'h03;
   localparam logic [7:0] CH_CMD    = 8'h35;
   localparam logic [7:0] CH_BOARD  = 8'h38;
   localparam logic [7:0] CH_SETTLE = 8'h30;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   // reset value of the payload pair limit
   localparam logic [7:0] MAX_PAIRS_RESET = 8'd25;

   // result kinds
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_REJECT  = 2'd2,
      KIND_BOARD   = 2'd3
   } kind_type;

   // one result beat
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_data;
      logic [8:0]  payload_count;
   } result_type;

   // hex character to nibble, bit 4 set when not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         v = {1'b0, c[3:0] + 4'd9};
      end
      return v;
   endfunction

endpackage

// ----- hw/rtl/mfp_in_stage.sv -----
// input register stage for received bytes
module mfp_in_stage
   import mfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       take,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic [7:0] data_in;

   // register is free when empty or drained this cycle
   assign req_tready = !valid_ff || take;

   // next beat load
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         data_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

// ----- hw/rtl/mfp_parser.sv -----
// frame parse state and per-byte update logic
module mfp_parser
   import mfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   input  logic [7:0] max_pairs,
   output logic       res_valid,
   output result_type res
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_STX, PH_CMD, PH_ST1, PH_ST2, PH_ETX,
      PH_CKH, PH_CKL, PH_CNTH, PH_CNTL, PH_PAY
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       settle_ff, settle_in;
   logic [7:0] sum_ff, sum_in;
   logic [8:0] left_ff, left_in;
   logic [8:0] total_ff, total_in;
   logic [3:0] nib_ff, nib_in;
   logic       zok_ff, zok_in;

   logic [4:0] hex;
   logic [7:0] pair;
   logic [7:0] sum_add;
   logic       fail;
   logic       idle;

   assign hex     = hex_value(rx_byte);
   assign pair    = {nib_ff, hex[3:0]};
   assign sum_add = sum_ff + rx_byte;

   // next parse state and result for the byte in the input register
   always_comb begin
      phase_in  = phase_ff;
      settle_in = settle_ff;
      sum_in    = sum_ff;
      left_in   = left_ff;
      total_in  = total_ff;
      nib_in    = nib_ff;
      zok_in    = zok_ff;
      res_valid = 1'b0;
      res       = '0;
      fail      = 1'b0;
      idle      = 1'b0;

      if (rx_byte == CH_STX) begin
         // restart, closing an open settlement frame
         if (settle_ff) begin
            res_valid         = 1'b1;
            res.kind          = KIND_REJECT;
            res.payload_count = total_ff;
         end
         idle = 1'b1;
      end else begin
         case (phase_ff)
            PH_STX: begin
               if (rx_byte == CH_CMD) begin
                  sum_in   = rx_byte;
                  phase_in = PH_CMD;
               end else begin
                  idle = 1'b1;
               end
            end
            PH_CMD: begin
               if (rx_byte == CH_BOARD) begin
                  sum_in   = sum_add;
                  phase_in = PH_ST1;
               end else if (rx_byte == CH_SETTLE) begin
                  sum_in    = sum_add;
                  settle_in = 1'b1;
                  phase_in  = PH_CNTH;
               end else begin
                  idle = 1'b1;
               end
            end
            PH_ST1: begin
               sum_in   = sum_add;
               zok_in   = (rx_byte == CH_ZERO);
               phase_in = PH_ST2;
            end
            PH_ST2: begin
               sum_in   = sum_add;
               zok_in   = zok_ff && (rx_byte == CH_ZERO);
               phase_in = PH_ETX;
            end
            PH_CNTH: begin
               if (hex[4]) begin
                  fail = 1'b1;
               end else begin
                  nib_in   = hex[3:0];
                  sum_in   = sum_add;
                  phase_in = PH_CNTL;
               end
            end
            PH_CNTL: begin
               if (hex[4] || pair > max_pairs) begin
                  fail = 1'b1;
               end else begin
                  sum_in   = sum_add;
                  left_in  = {pair, 1'b0};
                  total_in = '0;
                  phase_in = (pair == 8'd0) ? PH_ETX : PH_PAY;
               end
            end
            PH_PAY: begin
               sum_in           = sum_add;
               total_in         = total_ff + 9'd1;
               left_in          = left_ff - 9'd1;
               if (left_ff == 9'd1) begin
                  phase_in = PH_ETX;
               end
               res_valid        = 1'b1;
               res.kind         = KIND_PAYLOAD;
               res.payload_data = rx_byte;
            end
            PH_ETX: begin
               if (rx_byte != CH_ETX) begin
                  fail = 1'b1;
               end else begin
                  phase_in = PH_CKH;
               end
            end
            PH_CKH: begin
               if (hex[4]) begin
                  fail = 1'b1;
               end else begin
                  nib_in   = hex[3:0];
                  phase_in = PH_CKL;
               end
            end
            PH_CKL: begin
               if (hex[4]) begin
                  fail = 1'b1;
               end else begin
                  if (settle_ff) begin
                     res_valid         = 1'b1;
                     res.kind          = (pair == sum_ff) ? KIND_ACCEPT : KIND_REJECT;
                     res.payload_count = total_ff;
                  end else if (pair == sum_ff && zok_ff) begin
                     res_valid = 1'b1;
                     res.kind  = KIND_BOARD;
                  end
                  idle = 1'b1;
               end
            end
            default: begin
               idle = 1'b1;
            end
         endcase

         // fault closes the frame, rejecting a settlement
         if (fail) begin
            if (settle_ff) begin
               res_valid         = 1'b1;
               res.kind          = KIND_REJECT;
               res.payload_count = total_ff;
            end
            idle = 1'b1;
         end
      end

      // clear frame state
      if (idle) begin
         phase_in  = (rx_byte == CH_STX) ? PH_STX : PH_IDLE;
         settle_in = 1'b0;
         sum_in    = '0;
         left_in   = '0;
         total_in  = '0;
         nib_in    = '0;
         zok_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         settle_ff <= 1'b0;
         sum_ff    <= '0;
         left_ff   <= '0;
         total_ff  <= '0;
         nib_ff    <= '0;
         zok_ff    <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         settle_ff <= settle_in;
         sum_ff    <= sum_in;
         left_ff   <= left_in;
         total_ff  <= total_in;
         nib_ff    <= nib_in;
         zok_ff    <= zok_in;
      end
   end

endmodule

// ----- hw/rtl/mfp_out_stage.sv -----
// result register stage
module mfp_out_stage
   import mfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        res_valid,
   input  result_type  res,
   output logic        room,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic [1:0]  rsp_tuser
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;
   result_type res_in;

   // free when empty or the held beat leaves this cycle
   assign room = !valid_ff || rsp_tready;

   // load on every processed byte, valid only when it gave a result
   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      res_in   = res_ff;
      if (step) begin
         valid_in = res_valid;
         res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, res_ff.payload_count, res_ff.payload_data};
   assign rsp_tuser  = res_ff.kind;

endmodule

// ----- hw/rtl/meter_frame_parser.sv -----
// top level: input register, frame parser, result register
// a result beat is registered in the result register when the parser takes its byte from the input register
// throughput: one byte per cycle while the result register has room, set by the single-pass parse update
// a stalled result register holds the parser and then the input register
// reset: synchronous active high; parser idle, both stages empty, limit 25
module meter_frame_parser
   import mfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] payload_data, [16:8] payload_count, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // [7:0] max_payload_pairs
);

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       room;
   logic       step;
   logic       res_valid;
   result_type res;
   logic [7:0] max_pairs_ff;

   // pair limit register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         max_pairs_ff <= MAX_PAIRS_RESET;
      end else if (csr_valid) begin
         max_pairs_ff <= csr_data;
      end
   end

   // byte moves through the parser when the result stage has room
   assign step = byte_valid && room;

   mfp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (step),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   mfp_parser u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (byte_data),
      .max_pairs (max_pairs_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   mfp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .res_valid  (res_valid),
      .res        (res),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
